[sv/icy_mi_pkg.sv]
// ----------------------------------------------------------------------------
// ICY metadata interleaver package
// Shared sizes, operation codes and register indexes of the interleaver.
// ----------------------------------------------------------------------------
package icy_mi_pkg;

    // Store depths and the widths that follow from them.
    localparam int AUDIO_DEPTH = 4096;
    localparam int META_DEPTH  = 4096;

    localparam int AUDIO_AW = $clog2(AUDIO_DEPTH);
    localparam int AUDIO_CW = $clog2(AUDIO_DEPTH + 1);
    localparam int META_AW  = $clog2(META_DEPTH);
    localparam int META_PW  = $clog2(META_DEPTH + 1);

    // Field and register widths.
    localparam int OP_W       = 2;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int INTERVAL_W = 16;
    localparam int FLUSH_W    = 13;

    // Common width for comparing the queue fill against the flush limit.
    localparam int LIMIT_W = (AUDIO_CW > FLUSH_W) ? AUDIO_CW : FLUSH_W;

    // Reset values of the configuration registers.
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd8192;
    localparam logic [FLUSH_W-1:0]    FLUSH_RESET    = 13'd4000;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 2'd0,
        OP_LOAD = 2'd1,
        OP_SLOT = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_METADATA_ON   = 2'd0,
        CFG_META_INTERVAL = 2'd1,
        CFG_FLUSH_LIMIT   = 2'd2
    } t_cfg_idx;

    typedef logic [AUDIO_AW-1:0] t_audio_addr;
    typedef logic [AUDIO_CW-1:0] t_audio_cnt;
    typedef logic [META_PW-1:0]  t_meta_pos;
    typedef logic [LIMIT_W-1:0]  t_limit;

endpackage

[sv/icy_metadata_stream_interleaver_top.sv]
// ----------------------------------------------------------------------------
// ICY metadata stream interleaver
// Audio byte queue with periodic insertion of ICY metadata blocks.
// ----------------------------------------------------------------------------
// How the block is used:
// The input channel (i_in_valid / o_in_ready) carries one operation per beat:
// push an audio byte, load a metadata byte (i_meta_last commits the block),
// or grant one output slot. A granted slot with audio queued produces one
// beat on the output channel (o_out_valid / i_out_ready): either an audio
// byte, the next byte of the pending metadata block, or a single zero byte
// when metadata is due but no block is pending.
// The configuration channel (i_cfg_valid / o_cfg_ready) writes metadata_on,
// meta_interval and flush_limit by index; it is always ready and must only
// be used while the block is idle.
// Throughput is one input beat per clock unless the receiver stalls the output.
// An accepted slot goes through the synchronous read of the audio or metadata
// memory, then through the output register.
// When the receiver stalls, the output register and the read stage behind it
// both hold; input beats keep flowing until that read stage is occupied.
// Reset empties the queue, drops any pending block and restores the register
// defaults. The two byte memories are not cleared; no entry is ever read
// before it has been written, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
module icy_metadata_stream_interleaver_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [icy_mi_pkg::OP_W-1:0]         i_op,
    input  logic [icy_mi_pkg::BYTE_W-1:0]       i_byte_value,
    input  logic                                i_meta_last,
    // Output channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [icy_mi_pkg::BYTE_W-1:0]       o_out_byte,
    output logic                                o_is_metadata,
    output logic                                o_flushed,
    // Configuration channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [icy_mi_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [icy_mi_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import icy_mi_pkg::*;

    localparam t_audio_addr AUDIO_LAST   = t_audio_addr'(AUDIO_DEPTH - 1);
    localparam t_audio_cnt  AUDIO_FULL   = t_audio_cnt'(AUDIO_DEPTH);
    localparam t_meta_pos   META_FULL    = t_meta_pos'(META_DEPTH);
    localparam logic [INTERVAL_W-1:0] BSM_MAX = '1;

    // Configuration registers.
    logic                   r_metadata_on;
    logic [INTERVAL_W-1:0]  r_meta_interval;
    logic [FLUSH_W-1:0]     r_flush_limit;

    // Memories and their registered read data.
    logic [BYTE_W-1:0] r_audio_mem [AUDIO_DEPTH];
    logic [BYTE_W-1:0] r_meta_mem  [META_DEPTH];
    logic [BYTE_W-1:0] r_audio_q;
    logic [BYTE_W-1:0] r_meta_q;

    // Queue and metadata control state.
    t_audio_addr            r_audio_head, n_audio_head;
    t_audio_addr            r_audio_tail, n_audio_tail;
    t_audio_cnt             r_audio_count, n_audio_count;
    t_meta_pos              r_meta_length, n_meta_length;
    t_meta_pos              r_meta_write_pos, n_meta_write_pos;
    t_meta_pos              r_meta_read_pos, n_meta_read_pos;
    logic                   r_meta_pending, n_meta_pending;
    logic [INTERVAL_W-1:0]  r_bytes_since_meta, n_bytes_since_meta;

    // Read stage and output register.
    logic                   r_s1_valid, n_s1_valid;
    logic                   r_s1_is_meta, n_s1_is_meta;
    logic                   r_s1_zero, n_s1_zero;
    logic                   r_out_valid;
    logic [BYTE_W-1:0]      r_out_byte;
    logic                   r_out_is_meta;

    // Memory access strobes.
    logic                   audio_we, audio_re, meta_we, meta_re;
    t_audio_addr            audio_waddr;
    logic                   in_fire, s1_advance;
    logic                   due;
    logic [INTERVAL_W-1:0]  interval;
    t_audio_cnt             count_eff;
    t_audio_addr            tail_eff;
    t_meta_pos              rp_inc, wp_eff;

    // The read stage moves on whenever the output register is free or drains.
    assign s1_advance  = !r_out_valid || i_out_ready;
    assign o_in_ready  = !r_s1_valid || s1_advance;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    assign interval = (r_meta_interval == '0) ? INTERVAL_W'(1) : r_meta_interval;
    assign due      = r_metadata_on && (r_bytes_since_meta >= interval);

    always_comb begin
        n_audio_head       = r_audio_head;
        n_audio_tail       = r_audio_tail;
        n_audio_count      = r_audio_count;
        n_meta_length      = r_meta_length;
        n_meta_write_pos   = r_meta_write_pos;
        n_meta_read_pos    = r_meta_read_pos;
        n_meta_pending     = r_meta_pending;
        n_bytes_since_meta = r_bytes_since_meta;
        n_s1_valid         = 1'b0;
        n_s1_is_meta       = 1'b0;
        n_s1_zero          = 1'b0;
        audio_we           = 1'b0;
        audio_re           = 1'b0;
        meta_we            = 1'b0;
        meta_re            = 1'b0;
        rp_inc             = r_meta_read_pos + t_meta_pos'(1);
        wp_eff             = r_meta_write_pos;

        // A push over the flush limit restarts the queue before writing.
        if (t_limit'(r_audio_count) > t_limit'(r_flush_limit)) begin
            count_eff = '0;
            tail_eff  = '0;
        end else begin
            count_eff = r_audio_count;
            tail_eff  = r_audio_tail;
        end
        audio_waddr = tail_eff;

        if (in_fire) begin
            if (i_op == OP_PUSH) begin
                n_audio_count = count_eff;
                n_audio_tail  = tail_eff;
                if (count_eff != r_audio_count || tail_eff != r_audio_tail) begin
                    n_audio_head = '0;
                end
                if (t_limit'(r_audio_count) > t_limit'(r_flush_limit)) begin
                    n_audio_head = '0;
                end
                if (count_eff < AUDIO_FULL) begin
                    audio_we      = 1'b1;
                    n_audio_tail  = (tail_eff == AUDIO_LAST) ? '0 : tail_eff + t_audio_addr'(1);
                    n_audio_count = count_eff + t_audio_cnt'(1);
                end
            end else if (i_op == OP_LOAD) begin
                if (r_meta_write_pos < META_FULL) begin
                    meta_we = 1'b1;
                    wp_eff  = r_meta_write_pos + t_meta_pos'(1);
                end
                n_meta_write_pos = wp_eff;
                if (i_meta_last) begin
                    n_meta_length    = wp_eff;
                    n_meta_write_pos = '0;
                    n_meta_read_pos  = '0;
                    n_meta_pending   = 1'b1;
                end
            end else if (i_op == OP_SLOT && r_audio_count != '0) begin
                n_s1_valid = 1'b1;
                if (due) begin
                    n_s1_is_meta = 1'b1;
                    if (r_meta_pending && r_meta_read_pos < r_meta_length) begin
                        meta_re         = 1'b1;
                        n_meta_read_pos = rp_inc;
                        if (rp_inc >= r_meta_length) begin
                            n_bytes_since_meta = '0;
                            n_meta_read_pos    = '0;
                            n_meta_pending     = 1'b0;
                        end
                    end else begin
                        // Zero marker: metadata due with nothing to send.
                        n_s1_zero          = 1'b1;
                        n_bytes_since_meta = '0;
                        n_meta_read_pos    = '0;
                        n_meta_pending     = 1'b0;
                    end
                end else begin
                    audio_re      = 1'b1;
                    n_audio_head  = (r_audio_head == AUDIO_LAST) ? '0
                                                                 : r_audio_head + t_audio_addr'(1);
                    n_audio_count = r_audio_count - t_audio_cnt'(1);
                    if (r_metadata_on && r_bytes_since_meta != BSM_MAX) begin
                        n_bytes_since_meta = r_bytes_since_meta + INTERVAL_W'(1);
                    end
                end
            end
        end
    end

    // Byte memories: one write and one registered read per cycle each. A slot
    // never reads in the same cycle as a write to its memory, and a byte
    // written at one edge is visible to a read at the next, so no forwarding
    // path is needed.
    always_ff @(posedge i_clk) begin
        if (audio_we) begin
            r_audio_mem[audio_waddr] <= i_byte_value;
        end
        if (audio_re) begin
            r_audio_q <= r_audio_mem[r_audio_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (meta_we) begin
            r_meta_mem[r_meta_write_pos[META_AW-1:0]] <= i_byte_value;
        end
        if (meta_re) begin
            r_meta_q <= r_meta_mem[r_meta_read_pos[META_AW-1:0]];
        end
    end

    // Control state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_metadata_on      <= 1'b0;
            r_meta_interval    <= INTERVAL_RESET;
            r_flush_limit      <= FLUSH_RESET;
            r_audio_head       <= '0;
            r_audio_tail       <= '0;
            r_audio_count      <= '0;
            r_meta_length      <= '0;
            r_meta_write_pos   <= '0;
            r_meta_read_pos    <= '0;
            r_meta_pending     <= 1'b0;
            r_bytes_since_meta <= '0;
            r_s1_valid         <= 1'b0;
            r_out_valid        <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_METADATA_ON:   r_metadata_on   <= i_cfg_data[0];
                    CFG_META_INTERVAL: r_meta_interval <= i_cfg_data[INTERVAL_W-1:0];
                    CFG_FLUSH_LIMIT:   r_flush_limit   <= i_cfg_data[FLUSH_W-1:0];
                    default: ;
                endcase
            end
            r_audio_head       <= n_audio_head;
            r_audio_tail       <= n_audio_tail;
            r_audio_count      <= n_audio_count;
            r_meta_length      <= n_meta_length;
            r_meta_write_pos   <= n_meta_write_pos;
            r_meta_read_pos    <= n_meta_read_pos;
            r_meta_pending     <= n_meta_pending;
            r_bytes_since_meta <= n_bytes_since_meta;
            if (o_in_ready) begin
                r_s1_valid <= n_s1_valid;
            end
            if (s1_advance) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // Read stage payload and output register payload.
    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_s1_is_meta <= n_s1_is_meta;
            r_s1_zero    <= n_s1_zero;
        end
        if (s1_advance && r_s1_valid) begin
            r_out_is_meta <= r_s1_is_meta;
            if (r_s1_zero) begin
                r_out_byte <= '0;
            end else if (r_s1_is_meta) begin
                r_out_byte <= r_meta_q;
            end else begin
                r_out_byte <= r_audio_q;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_is_metadata = r_out_is_meta;
    assign o_flushed     = 1'b0;

`ifndef SYNTHESIS
    // The queue never holds more bytes than the audio memory has entries.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_audio_count <= AUDIO_FULL)
        else $error("audio count exceeds memory depth");

    // While a block is pending, the read position stays inside it.
    a_read_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_meta_pending |-> (r_meta_read_pos < r_meta_length))
        else $error("metadata read position outside committed block");

    // A read stage blocked by a stalled output keeps its beat.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !i_out_ready) |=> r_s1_valid)
        else $error("read stage lost a beat during output stall");

    // A slot is only taken into the read stage when the queue had audio.
    a_slot_needs_audio: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_op == OP_SLOT && r_audio_count == '0) |=> !r_s1_valid)
        else $error("slot with empty queue produced a beat");
`endif

endmodule

[verif/tb_icy_metadata_stream_interleaver_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the ICY metadata stream interleaver
// Drives push, load and slot beats with random gaps, stalls the output side
// at random and for long stretches, predicts every output byte from a local
// copy of the queue and metadata state, and checks each output beat in order.
// ----------------------------------------------------------------------------
module tb_icy_metadata_stream_interleaver_top;
    import icy_mi_pkg::*;

    // ------------------------------------------------------------------------
    // Run constants.
    // ------------------------------------------------------------------------
    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 12;
    localparam int MAX_WAIT     = 18;
    // A slot comes out through the read stage and the output register; the drain
    // time covers the beats that produce nothing but may still sit in the pipeline.
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_BEATS  = 90;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_MARK_A  = 200;
    localparam int HOLD_MARK_B  = 500;
    localparam int REPORT_LIMIT = 10;

    // Codes that the block is expected to ignore.
    localparam logic [OP_W-1:0]      OP_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // One input beat as queued for the driver.
    typedef struct {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] value;
        logic              last;
        int unsigned       wait_cycles;
    } t_stream_op;

    // One output beat as predicted.
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              is_metadata;
        logic              flushed;
    } t_slot_byte;

    // ------------------------------------------------------------------------
    // Clock, reset and block ports. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_in_valid   = 1'b0;
    logic                  o_in_ready;
    logic [OP_W-1:0]       i_op         = OP_PUSH;
    logic [BYTE_W-1:0]     i_byte_value = '0;
    logic                  i_meta_last  = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready  = 1'b0;
    logic [BYTE_W-1:0]     o_out_byte;
    logic                  o_is_metadata;
    logic                  o_flushed;
    logic                  i_cfg_valid  = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data   = '0;

    always #CLK_HALF i_clk = ~i_clk;

    icy_metadata_stream_interleaver_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_op          (i_op),
        .i_byte_value  (i_byte_value),
        .i_meta_last   (i_meta_last),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_is_metadata (o_is_metadata),
        .o_flushed     (o_flushed),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // Predicted state of the interleaver and its registers. The registers
    // change only between phases, while the block is idle.
    // ------------------------------------------------------------------------
    logic                  cfg_on       = 1'b0;
    logic [INTERVAL_W-1:0] cfg_interval = INTERVAL_RESET;
    logic [FLUSH_W-1:0]    cfg_flush    = FLUSH_RESET;

    logic [BYTE_W-1:0]     audio_mem [AUDIO_DEPTH];
    logic [BYTE_W-1:0]     meta_mem  [META_DEPTH];
    t_audio_addr           audio_rd_ptr = '0;
    t_audio_addr           audio_wr_ptr = '0;
    t_audio_cnt            audio_fill   = '0;
    t_meta_pos             meta_len     = '0;
    t_meta_pos             meta_wr_pos  = '0;
    t_meta_pos             meta_rd_pos  = '0;
    logic                  meta_armed   = 1'b0;
    logic [INTERVAL_W-1:0] since_insert = '0;

    t_slot_byte  slot_bytes_due[$];
    t_stream_op  stream_ops_pending[$];
    int unsigned fail_count = 0;

    // Applies one accepted input beat to the predicted state and records the
    // byte that its slot will carry, if any.
    task automatic interleave_step(logic [OP_W-1:0] op, logic [BYTE_W-1:0] value,
                                   logic last);
        logic [INTERVAL_W-1:0] interval;
        t_slot_byte            slot;
        if (op == OP_PUSH) begin
            // An overfull queue is cleared before the new byte goes in.
            if (int'(audio_fill) > int'(cfg_flush)) begin
                audio_rd_ptr = '0;
                audio_wr_ptr = '0;
                audio_fill   = '0;
            end
            if (int'(audio_fill) < AUDIO_DEPTH) begin
                audio_mem[audio_wr_ptr] = value;
                audio_wr_ptr            = audio_wr_ptr + 1'b1;
                audio_fill              = audio_fill + 1'b1;
            end
        end else if (op == OP_LOAD) begin
            // Bytes past the end of the store are dropped, a last mark still
            // commits the block.
            if (int'(meta_wr_pos) < META_DEPTH) begin
                meta_mem[meta_wr_pos[META_AW-1:0]] = value;
                meta_wr_pos                        = meta_wr_pos + 1'b1;
            end
            if (last) begin
                meta_len    = meta_wr_pos;
                meta_wr_pos = '0;
                meta_rd_pos = '0;
                meta_armed  = 1'b1;
            end
        end else if (op == OP_SLOT && audio_fill != '0) begin
            interval      = (cfg_interval == '0) ? INTERVAL_W'(1) : cfg_interval;
            slot.flushed  = 1'b0;
            if (cfg_on && since_insert >= interval) begin
                slot.is_metadata = 1'b1;
                if (meta_armed && meta_rd_pos < meta_len) begin
                    slot.out_byte = meta_mem[meta_rd_pos[META_AW-1:0]];
                    meta_rd_pos   = meta_rd_pos + 1'b1;
                    if (meta_rd_pos >= meta_len) begin
                        since_insert = '0;
                        meta_rd_pos  = '0;
                        meta_armed   = 1'b0;
                    end
                end else begin
                    // Nothing pending: a single zero byte marks the point.
                    slot.out_byte = '0;
                    since_insert  = '0;
                    meta_rd_pos   = '0;
                    meta_armed    = 1'b0;
                end
            end else begin
                slot.is_metadata = 1'b0;
                slot.out_byte    = audio_mem[audio_rd_ptr];
                audio_rd_ptr     = audio_rd_ptr + 1'b1;
                audio_fill       = audio_fill - 1'b1;
                if (cfg_on && since_insert != '1)
                    since_insert = since_insert + 1'b1;
            end
            slot_bytes_due.push_back(slot);
        end
    endtask

    // ------------------------------------------------------------------------
    // Idle pattern. Each side keeps a mode: in calm stretches it never waits,
    // otherwise about half of its beats wait a random number of cycles.
    // ------------------------------------------------------------------------
    bit send_calm    = 1'b0;
    bit recv_calm    = 1'b0;

    function automatic int unsigned draw_wait(bit calm);
        if (calm || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, MAX_WAIT);
    endfunction

    task automatic queue_op(logic [OP_W-1:0] op, logic [BYTE_W-1:0] value, logic last);
        t_stream_op item;
        if ($urandom_range(0, 39) == 0)
            send_calm = !send_calm;
        item.op          = op;
        item.value       = value;
        item.last        = last;
        item.wait_cycles = draw_wait(send_calm);
        stream_ops_pending.push_back(item);
    endtask

    // ------------------------------------------------------------------------
    // Input driver. A beat is taken from the pending queue, held back for its
    // drawn gap, then offered until the block accepts it. The prediction is
    // made at the edge that accepts the beat.
    // ------------------------------------------------------------------------
    t_stream_op  staged_op;
    bit          op_staged     = 1'b0;
    int unsigned gap_left      = 0;
    int unsigned accepted_beats = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            op_staged  = 1'b0;
            gap_left   = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                interleave_step(staged_op.op, staged_op.value, staged_op.last);
                accepted_beats <= accepted_beats + 1;
                op_staged = 1'b0;
            end
            if (!op_staged && stream_ops_pending.size() != 0) begin
                staged_op = stream_ops_pending.pop_front();
                op_staged = 1'b1;
                gap_left  = staged_op.wait_cycles;
            end
            if (op_staged && gap_left == 0) begin
                i_in_valid   <= 1'b1;
                i_op         <= staged_op.op;
                i_byte_value <= staged_op.value;
                i_meta_last  <= staged_op.last;
            end else begin
                i_in_valid <= 1'b0;
                if (op_staged)
                    gap_left = gap_left - 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Long receiver hold-off. Twice during the random traffic the output side
    // refuses beats for a long stretch while the sender keeps offering, so
    // the block backs up and has to stall its input.
    // ------------------------------------------------------------------------
    int unsigned hold_left  = 0;
    int unsigned holds_done = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left  <= 0;
            holds_done <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (holds_done < 2 &&
                     accepted_beats >= ((holds_done == 0) ? HOLD_MARK_A : HOLD_MARK_B)) begin
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Output monitor. Each accepted output beat is compared field by field
    // with the oldest predicted byte; after it the receiver draws its stall.
    // ------------------------------------------------------------------------
    int unsigned stall_left = 0;
    t_slot_byte  want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left  = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (slot_bytes_due.size() == 0) begin
                    fail_count = fail_count + 1;
                    if (fail_count <= REPORT_LIMIT)
                        $display("ERROR: unexpected output beat byte=%02h meta=%b flushed=%b",
                                 o_out_byte, o_is_metadata, o_flushed);
                end else begin
                    want = slot_bytes_due.pop_front();
                    if (o_out_byte !== want.out_byte || o_is_metadata !== want.is_metadata ||
                        o_flushed !== want.flushed) begin
                        fail_count = fail_count + 1;
                        if (fail_count <= REPORT_LIMIT)
                            $display({"ERROR: output beat mismatch expected byte=%02h meta=%b ",
                                      "flushed=%b, got byte=%02h meta=%b flushed=%b"},
                                     want.out_byte, want.is_metadata, want.flushed,
                                     o_out_byte, o_is_metadata, o_flushed);
                    end
                end
                if ($urandom_range(0, 39) == 0)
                    recv_calm = !recv_calm;
                stall_left = draw_wait(recv_calm);
            end else if (stall_left != 0) begin
                stall_left = stall_left - 1;
            end
            i_out_ready <= (stall_left == 0) && (hold_left == 0);
        end
    end

    // ------------------------------------------------------------------------
    // Configuration writes, only issued while the block is idle.
    // ------------------------------------------------------------------------
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_METADATA_ON)
            cfg_on = data[0];
        else if (idx == CFG_META_INTERVAL)
            cfg_interval = data;
        else if (idx == CFG_FLUSH_LIMIT)
            cfg_flush = data[FLUSH_W-1:0];
    endtask

    // The upper bits of the enable word are random, since only bit 0 counts.
    // A write to the unused index goes along with every setting.
    task automatic set_config(logic on, logic [CFG_DATA_W-1:0] interval,
                              logic [CFG_DATA_W-1:0] flush);
        write_reg(CFG_METADATA_ON, {15'($urandom_range(0, 32767)), on});
        write_reg(CFG_META_INTERVAL, interval);
        write_reg(CFG_FLUSH_LIMIT, flush);
        write_reg(CFG_UNUSED, 16'($urandom_range(0, 65535)));
    endtask

    // Waits until every queued beat is accepted and every predicted byte has
    // come out, then lets the pipeline settle.
    task automatic wait_drained();
        while (stream_ops_pending.size() != 0 || op_staged || i_in_valid ||
               slot_bytes_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Random traffic built mostly from well-formed runs: bursts of audio,
    // whole metadata blocks, runs of slots. Some blocks are left open, and a
    // little noise (unknown ops, one-byte blocks) is mixed in.
    task automatic queue_random_traffic(int unsigned beats);
        int unsigned made;
        int unsigned run;
        int unsigned kind;
        made = 0;
        while (made < beats) begin
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
                run = $urandom_range(1, 12);
                repeat (run)
                    queue_op(OP_PUSH, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                made = made + run;
            end else if (kind < 60) begin
                run = $urandom_range(1, 6);
                for (int i = 0; i < run; i++)
                    queue_op(OP_LOAD, 8'($urandom_range(0, 255)),
                             (i == run - 1) && ($urandom_range(0, 7) != 0));
                made = made + run;
            end else if (kind < 95) begin
                run = $urandom_range(1, 10);
                repeat (run)
                    queue_op(OP_SLOT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                made = made + run;
            end else begin
                queue_op(OP_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                if ($urandom_range(0, 1) == 1) begin
                    queue_op(OP_LOAD, 8'($urandom_range(0, 255)), 1'b1);
                    made = made + 1;
                end
            end
        end
    endtask

    task automatic run_random_phase(logic on, logic [CFG_DATA_W-1:0] interval,
                                    logic [CFG_DATA_W-1:0] flush);
        set_config(on, interval, flush);
        queue_random_traffic(PHASE_BEATS);
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Stimulus sequence.
    // ------------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings, metadata off. A slot on an empty queue gives
        // nothing, an unknown op is ignored, and the byte extremes pass.
        queue_op(OP_SLOT, 8'h00, 1'b0);
        queue_op(OP_PUSH, 8'h00, 1'b0);
        queue_op(OP_PUSH, 8'hFF, 1'b1);
        queue_op(OP_UNUSED, 8'h77, 1'b1);
        queue_op(OP_SLOT, 8'hFF, 1'b1);
        queue_op(OP_SLOT, 8'h00, 1'b0);
        queue_op(OP_SLOT, 8'h00, 1'b0);
        wait_drained();

        // Interval zero acts as one: audio and metadata alternate. The block
        // completes, then the next insertion point finds nothing pending and
        // sends the zero marker; the last slot finds the queue empty.
        set_config(1'b1, 16'd0, 16'd8191);
        queue_op(OP_LOAD, 8'h80, 1'b0);
        queue_op(OP_LOAD, 8'h7F, 1'b1);
        queue_op(OP_PUSH, 8'hA5, 1'b0);
        queue_op(OP_PUSH, 8'h5A, 1'b0);
        queue_op(OP_PUSH, 8'h3C, 1'b0);
        repeat (7) queue_op(OP_SLOT, 8'h00, 1'b0);
        wait_drained();

        // Flush: the third push finds more than the limit queued and clears.
        set_config(1'b0, 16'hFFFF, 16'd1);
        queue_op(OP_PUSH, 8'h11, 1'b0);
        queue_op(OP_PUSH, 8'h22, 1'b0);
        queue_op(OP_PUSH, 8'h33, 1'b0);
        queue_op(OP_SLOT, 8'h00, 1'b0);
        queue_op(OP_SLOT, 8'h00, 1'b0);
        wait_drained();

        // Random traffic over a range of settings. The widest interval lets the
        // count of bytes since the last insertion climb, then the next phase lowers
        // the interval below it.
        run_random_phase(1'b1, 16'd1, 16'd0);
        run_random_phase(1'b1, 16'd65535, 16'd4096);
        run_random_phase(1'b1, 16'd2, 16'd20);
        run_random_phase(1'b0, 16'($urandom_range(1, 65535)), 16'd4000);
        run_random_phase(1'b1, 16'd0, 16'hFFFF);
        run_random_phase(1'b1, 16'($urandom_range(1, 8)), 16'($urandom_range(5, 60)));
        run_random_phase(1'b1, 16'd3, 16'd7);

        if (fail_count == 0 && slot_bytes_due.size() == 0) begin
            $display("PASS icy_metadata_stream_interleaver_top");
        end else begin
            $display("FAIL icy_metadata_stream_interleaver_top");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #30_000_000;
        $display("FAIL icy_metadata_stream_interleaver_top");
        $finish;
    end

endmodule
